>>> rtl/ddhm_pkg.sv
// shared types and constants for the differential drive heading-hold mixer
package ddhm_pkg;

  typedef enum logic [3:0] {
    MODE_STOP       = 4'd0,
    MODE_FWD        = 4'd1,
    MODE_BACK       = 4'd2,
    MODE_LEFT       = 4'd3,
    MODE_RIGHT      = 4'd4,
    MODE_FWD_LEFT   = 4'd5,
    MODE_BACK_LEFT  = 4'd6,
    MODE_FWD_RIGHT  = 4'd7,
    MODE_BACK_RIGHT = 4'd8
  } mode_e;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LOWER = 3'd4;

  localparam logic [7:0] MIN_SPEED_RST   = 8'd0;
  localparam logic [7:0] MAX_SPEED_RST   = 8'd255;
  localparam logic [7:0] GAIN_RST        = 8'd10;
  localparam logic [7:0] WHEEL_UPPER_RST = 8'd255;
  localparam logic [7:0] WHEEL_LOWER_RST = 8'd10;

  // latched record value that matches no drive mode
  localparam logic [3:0] REC_NONE = 4'hF;

endpackage

>>> rtl/diff_drive_heading_hold_mixer_unit.sv
// top level of the differential drive mixer with proportional heading hold
// One drive command is taken per cycle while in_stall_o is low. A command enters an
// input register and moves on into the result register once that register is empty
// or its held transaction is not stalled by the result side. The sustained rate is
// one command per clock while the result side does not stall. The longest path is
// the 17x9 signed yaw error times gain product feeding the truncation and wheel
// clamp. The heading latch and mode record update as each command moves into the
// result register, so commands are handled strictly in order. Configuration
// writes are taken at any time (ready is always high) and must only be issued
// while no command is in flight.
module diff_drive_heading_hold_mixer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [3:0]                       drive_mode_i,
  input  logic [7:0]                       speed_request_i,
  input  logic signed [15:0]               yaw_now_i,
  // wheel command channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             drive_enable_o,
  output logic                             right_dir_o,
  output logic [7:0]                       right_speed_o,
  output logic                             left_dir_o,
  output logic [7:0]                       left_speed_o,
  output logic                             bad_mode_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ddhm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]                       cfg_data_i
);
  import ddhm_pkg::*;

  // configuration
  logic [7:0] min_speed_q, max_speed_q, gain_q, wheel_upper_q, wheel_lower_q;

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic [3:0]        s1_mode_q;
  logic [7:0]        s1_speed_q;
  logic signed [15:0] s1_yaw_q;

  // heading state
  logic [3:0]  mode_record_q, mode_record_d;
  logic [3:0]  latched_record_q, latched_record_d;
  logic [15:0] heading_ref_q, heading_ref_d;

  // result stage
  logic       out_valid_q, out_valid_d;
  logic       enable_d, rdir_d, ldir_d, bad_d;
  logic [7:0] rspd_d, lspd_d;
  logic       enable_q, rdir_q, ldir_q, bad_q;
  logic [7:0] rspd_q, lspd_q;

  logic in_accept, advance;

  logic [7:0]         s_lo, s_clamped, s_half;
  logic               latch_now;
  logic signed [16:0] yaw_err;
  logic signed [25:0] prod, base, sum_r, sum_l;
  logic [7:0]         wheel_r, wheel_l;

  function automatic logic [7:0] wheel_lim(input logic signed [25:0] sum,
                                           input logic [7:0] up,
                                           input logic [7:0] lo);
    logic signed [25:0] trunc_v;
    logic [7:0]         res;
    // divide by 16 rounding toward zero
    trunc_v = (sum + (sum[25] ? 26'sd15 : 26'sd0)) >>> 4;
    if (trunc_v > $signed({18'b0, up})) begin
      res = up;
    end else if (trunc_v < $signed({18'b0, lo})) begin
      res = lo;
    end else begin
      res = trunc_v[7:0];
    end
    return res;
  endfunction

  assign cfg_ready_o = 1'b1;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q   <= MIN_SPEED_RST;
      max_speed_q   <= MAX_SPEED_RST;
      gain_q        <= GAIN_RST;
      wheel_upper_q <= WHEEL_UPPER_RST;
      wheel_lower_q <= WHEEL_LOWER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_SPEED:   min_speed_q   <= cfg_data_i;
        CFG_MAX_SPEED:   max_speed_q   <= cfg_data_i;
        CFG_GAIN:        gain_q        <= cfg_data_i;
        CFG_WHEEL_UPPER: wheel_upper_q <= cfg_data_i;
        CFG_WHEEL_LOWER: wheel_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // speed clamp, upper bound wins when the bounds are inverted
  assign s_lo      = (s1_speed_q < min_speed_q) ? min_speed_q : s1_speed_q;
  assign s_clamped = (s_lo > max_speed_q) ? max_speed_q : s_lo;
  assign s_half    = {1'b0, s_clamped[7:1]};

  // a fresh latch makes the reference equal to this yaw, so the error is zero
  assign latch_now = (latched_record_q != mode_record_q);
  assign yaw_err   = latch_now ? 17'sd0
                   : ($signed({s1_yaw_q[15], s1_yaw_q})
                      - $signed({heading_ref_q[15], heading_ref_q}));
  assign prod      = 26'(yaw_err * $signed({1'b0, gain_q}));
  assign base      = $signed({14'b0, s_clamped, 4'b0});
  assign sum_r     = base + prod;
  assign sum_l     = base - prod;
  assign wheel_r   = wheel_lim(sum_r, wheel_upper_q, wheel_lower_q);
  assign wheel_l   = wheel_lim(sum_l, wheel_upper_q, wheel_lower_q);

  always_comb begin
    enable_d         = 1'b1;
    rdir_d           = 1'b0;
    ldir_d           = 1'b0;
    rspd_d           = '0;
    lspd_d           = '0;
    bad_d            = 1'b0;
    mode_record_d    = s1_mode_q;
    latched_record_d = latched_record_q;
    heading_ref_d    = heading_ref_q;
    unique case (s1_mode_q) inside
      MODE_FWD, MODE_BACK: begin
        if (latch_now) begin
          latched_record_d = mode_record_q;
          heading_ref_d    = s1_yaw_q;
        end
        if (s1_mode_q == MODE_FWD) begin
          rdir_d = 1'b1;
          ldir_d = 1'b1;
          rspd_d = wheel_r;
          lspd_d = wheel_l;
        end else begin
          // backward swaps the wheels
          rspd_d = wheel_l;
          lspd_d = wheel_r;
        end
      end
      MODE_LEFT: begin
        rdir_d = 1'b1;
        rspd_d = s_clamped;
        lspd_d = s_clamped;
      end
      MODE_RIGHT: begin
        ldir_d = 1'b1;
        rspd_d = s_clamped;
        lspd_d = s_clamped;
      end
      MODE_FWD_LEFT: begin
        rdir_d = 1'b1;
        ldir_d = 1'b1;
        rspd_d = s_clamped;
        lspd_d = s_half;
      end
      MODE_BACK_LEFT: begin
        rspd_d = s_clamped;
        lspd_d = s_half;
      end
      MODE_FWD_RIGHT: begin
        rdir_d = 1'b1;
        ldir_d = 1'b1;
        rspd_d = s_half;
        lspd_d = s_clamped;
      end
      MODE_BACK_RIGHT: begin
        rspd_d = s_half;
        lspd_d = s_clamped;
      end
      MODE_STOP: begin
        enable_d      = 1'b0;
        mode_record_d = mode_record_q;
      end
      default: begin
        enable_d      = 1'b0;
        bad_d         = 1'b1;
        mode_record_d = mode_record_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      mode_record_q    <= MODE_STOP;
      latched_record_q <= REC_NONE;
      heading_ref_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        mode_record_q    <= mode_record_d;
        latched_record_q <= latched_record_d;
        heading_ref_q    <= heading_ref_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q  <= drive_mode_i;
      s1_speed_q <= speed_request_i;
      s1_yaw_q   <= yaw_now_i;
    end
    if (advance) begin
      enable_q <= enable_d;
      rdir_q   <= rdir_d;
      ldir_q   <= ldir_d;
      rspd_q   <= rspd_d;
      lspd_q   <= lspd_d;
      bad_q    <= bad_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_enable_o = enable_q;
  assign right_dir_o    = rdir_q;
  assign right_speed_o  = rspd_q;
  assign left_dir_o     = ldir_q;
  assign left_speed_o   = lspd_q;
  assign bad_mode_o     = bad_q;

endmodule

>>> rtl/ddhm_checker.sv
// port-level checks for the differential drive mixer, bound to the top level
module ddhm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           drive_enable_o,
  input logic                           right_dir_o,
  input logic [7:0]                     right_speed_o,
  input logic                           left_dir_o,
  input logic [7:0]                     left_speed_o,
  input logic                           bad_mode_o
);

  // an invalid code never drives the motors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_mode_o |-> !drive_enable_o)
    else $error("bad mode result with drive enabled");

  // a stopped result carries zero duty on both wheels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_enable_o |-> right_speed_o == 8'd0 && left_speed_o == 8'd0)
    else $error("stopped result with nonzero wheel speed");

  // a stopped result has both direction bits low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !drive_enable_o |-> !right_dir_o && !left_dir_o)
    else $error("stopped result with a direction bit set");

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_enable_o)
      && $stable(right_speed_o) && $stable(left_speed_o) && $stable(bad_mode_o)
      && $stable(right_dir_o) && $stable(left_dir_o))
    else $error("stalled result changed");

endmodule

bind diff_drive_heading_hold_mixer_unit ddhm_checker u_ddhm_checker (.*);

>>> test/tb_top.sv
// self-checking testbench for the differential drive heading-hold mixer unit
module tb_top;
  import ddhm_pkg::*;

  // codes above the last drive mode are rejected by the block
  localparam logic [3:0] MODE_BAD_LO = 4'd9;
  localparam logic [3:0] MODE_BAD_HI = 4'd15;
  localparam int         ITEMS_PER_PHASE = 190;
  localparam int         NUM_PHASES = 6;
  localparam int         HOLD_CYCLES = 300;

  typedef struct packed {
    logic       en;
    logic       rdir;
    logic [7:0] rspd;
    logic       ldir;
    logic [7:0] lspd;
    logic       bad;
  } wheel_cmd_t;

  typedef struct {
    logic [3:0]        mode;
    logic [7:0]        spd;
    logic signed [15:0] yaw;
    bit                typed;
    wheel_cmd_t        res;
  } cmd_row_t;

  typedef struct {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] gain;
    logic [7:0] wup;
    logic [7:0] wlo;
    int         src_pct;
    int         sink_pct;
    bit         hold;
    bit         keep_reset;
    bit         rnd_regs;
  } phase_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [3:0]         drive_mode_i;
  logic [7:0]         speed_request_i;
  logic signed [15:0] yaw_now_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               drive_enable_o;
  logic               right_dir_o;
  logic [7:0]         right_speed_o;
  logic               left_dir_o;
  logic [7:0]         left_speed_o;
  logic               bad_mode_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]         cfg_data_i;

  // mirror of the block's registers and heading state
  logic [7:0]         cfg_min, cfg_max, cfg_gain, cfg_wup, cfg_wlo;
  logic [3:0]         mode_rec, latched_rec;
  logic signed [15:0] head_ref;

  wheel_cmd_t wheel_cmd_q[$];
  int         mismatches = 0;
  int         cmds_sent = 0;
  int         cmds_checked = 0;
  int         src_idle_pct = 0;
  int         sink_idle_pct = 0;
  bit         hold_req = 1'b0;
  bit         hold_seen = 1'b0;

  cmd_row_t directed_rows[22] = '{
    '{MODE_STOP,       8'd0,   16'sh0000, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0}},
    '{MODE_BAD_LO,     8'd255, 16'sh7FFF, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b1}},
    '{MODE_BAD_HI,     8'd128, 16'sh8000, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b1}},
    '{MODE_FWD,        8'd100, 16'sh0000, 1'b1, '{1'b1, 1'b1, 8'd100, 1'b1, 8'd100, 1'b0}},
    '{MODE_FWD,        8'd100, 16'sh00A0, 1'b0, '0},
    '{MODE_FWD,        8'd100, 16'sh0140, 1'b0, '0},
    '{MODE_FWD,        8'd255, 16'sh7FFF, 1'b0, '0},
    '{MODE_FWD,        8'd0,   16'sh8000, 1'b0, '0},
    '{MODE_BACK,       8'd50,  16'shFFF0, 1'b0, '0},
    '{MODE_BACK,       8'd50,  16'sh0009, 1'b0, '0},
    '{MODE_LEFT,       8'd255, 16'sh1234, 1'b1, '{1'b1, 1'b1, 8'd255, 1'b0, 8'd255, 1'b0}},
    '{MODE_RIGHT,      8'd0,   16'shABCD, 1'b1, '{1'b1, 1'b0, 8'd0,   1'b1, 8'd0,   1'b0}},
    '{MODE_FWD_LEFT,   8'd255, 16'sh0000, 1'b1, '{1'b1, 1'b1, 8'd255, 1'b1, 8'd127, 1'b0}},
    '{MODE_BACK_LEFT,  8'd1,   16'sh0000, 1'b1, '{1'b1, 1'b0, 8'd1,   1'b0, 8'd0,   1'b0}},
    '{MODE_FWD_RIGHT,  8'd200, 16'sh0000, 1'b1, '{1'b1, 1'b1, 8'd100, 1'b1, 8'd200, 1'b0}},
    '{MODE_BACK_RIGHT, 8'd201, 16'sh0000, 1'b1, '{1'b1, 1'b0, 8'd100, 1'b0, 8'd201, 1'b0}},
    '{MODE_STOP,       8'd77,  16'sh5555, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b0}},
    '{MODE_FWD,        8'd120, 16'shFFFF, 1'b0, '0},
    '{MODE_BAD_LO,     8'd0,   16'shFFFF, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0, 8'd0,   1'b1}},
    '{MODE_FWD,        8'd120, 16'shFFF3, 1'b0, '0},
    '{MODE_BACK,       8'd255, 16'sh0000, 1'b0, '0},
    '{MODE_BACK,       8'd200, 16'sh0040, 1'b0, '0}
  };

  // register settings per phase: reset values, extremes, inverted clamps, random, typical
  phase_t phase_tab[NUM_PHASES] = '{
    '{8'd0,   8'd255, 8'd10,  8'd255, 8'd10,  25, 25, 1'b0, 1'b1, 1'b0},
    '{8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   20, 40, 1'b0, 1'b0, 1'b0},
    '{8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 40, 10, 1'b0, 1'b0, 1'b0},
    '{8'd200, 8'd50,  8'd1,   8'd100, 8'd200, 0,  0,  1'b1, 1'b0, 1'b0},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   15, 15, 1'b0, 1'b0, 1'b1},
    '{8'd20,  8'd230, 8'd10,  8'd250, 8'd5,   0,  0,  1'b0, 1'b0, 1'b0}
  };

  diff_drive_heading_hold_mixer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .drive_mode_i    (drive_mode_i),
    .speed_request_i (speed_request_i),
    .yaw_now_i       (yaw_now_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_enable_o  (drive_enable_o),
    .right_dir_o     (right_dir_o),
    .right_speed_o   (right_speed_o),
    .left_dir_o      (left_dir_o),
    .left_speed_o    (left_speed_o),
    .bad_mode_o      (bad_mode_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] clamp_wheel(int v);
    if (v > int'(cfg_wup)) return cfg_wup;
    if (v < int'(cfg_wlo)) return cfg_wlo;
    return v[7:0];
  endfunction

  // wheel command for one drive command; advances the heading state
  function automatic wheel_cmd_t mix_drive_cmd(logic [3:0] mode, logic [7:0] spd_req,
                                               logic signed [15:0] yaw);
    wheel_cmd_t c;
    logic [7:0] s, half;
    int         err, prod, rv, lv;
    c = '0;
    s = spd_req;
    if (s < cfg_min) s = cfg_min;
    if (s > cfg_max) s = cfg_max;
    half = s >> 1;
    c.en = 1'b1;
    case (mode)
      MODE_FWD, MODE_BACK: begin
        if (latched_rec != mode_rec) begin
          latched_rec = mode_rec;
          head_ref = yaw;
        end
        err = int'(yaw) - int'(head_ref);
        prod = err * int'(cfg_gain);
        // division truncates the whole sum toward zero
        rv = int'(clamp_wheel((int'(s) * 16 + prod) / 16));
        lv = int'(clamp_wheel((int'(s) * 16 - prod) / 16));
        if (mode == MODE_FWD) begin
          c.rdir = 1'b1; c.ldir = 1'b1;
          c.rspd = rv[7:0]; c.lspd = lv[7:0];
        end else begin
          c.rspd = lv[7:0]; c.lspd = rv[7:0];
        end
        mode_rec = mode;
      end
      MODE_LEFT: begin
        c.rdir = 1'b1; c.rspd = s; c.lspd = s; mode_rec = mode;
      end
      MODE_RIGHT: begin
        c.ldir = 1'b1; c.rspd = s; c.lspd = s; mode_rec = mode;
      end
      MODE_FWD_LEFT: begin
        c.rdir = 1'b1; c.ldir = 1'b1; c.rspd = s; c.lspd = half; mode_rec = mode;
      end
      MODE_BACK_LEFT: begin
        c.rspd = s; c.lspd = half; mode_rec = mode;
      end
      MODE_FWD_RIGHT: begin
        c.rdir = 1'b1; c.ldir = 1'b1; c.rspd = half; c.lspd = s; mode_rec = mode;
      end
      MODE_BACK_RIGHT: begin
        c.rspd = half; c.lspd = s; mode_rec = mode;
      end
      MODE_STOP: begin
        c.en = 1'b0;
      end
      default: begin
        c.en = 1'b0;
        c.bad = 1'b1;
      end
    endcase
    return c;
  endfunction

  task automatic send_cmd(logic [3:0] mode, logic [7:0] spd, logic signed [15:0] yaw,
                          bit typed, wheel_cmd_t res);
    wheel_cmd_t pred;
    int         gap;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(15, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    drive_mode_i    <= mode;
    speed_request_i <= spd;
    yaw_now_i       <= yaw;
    do @(posedge clk_i); while (in_stall_o);
    pred = mix_drive_cmd(mode, spd, yaw);
    wheel_cmd_q.push_back(typed ? res : pred);
    cmds_sent++;
  endtask

  // caller lowers cfg_valid_i after the last write of a sequence
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_SPEED:   cfg_min = data;
      CFG_MAX_SPEED:   cfg_max = data;
      CFG_GAIN:        cfg_gain = data;
      CFG_WHEEL_UPPER: cfg_wup = data;
      CFG_WHEEL_LOWER: cfg_wlo = data;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    wheel_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (wheel_cmd_q.size() == 0) begin
        $error("wheel command transaction with none pending");
        mismatches++;
      end else begin
        want = wheel_cmd_q.pop_front();
        check_field("drive_enable", want.en, drive_enable_o);
        check_field("right_dir", want.rdir, right_dir_o);
        check_field("right_speed", want.rspd, right_speed_o);
        check_field("left_dir", want.ldir, left_dir_o);
        check_field("left_speed", want.lspd, left_speed_o);
        check_field("bad_mode", want.bad, bad_mode_o);
        cmds_checked++;
      end
    end
  end

  // result side stall: random bursts, plus one long hold-off on request
  initial begin : sink_side
    int n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          @(posedge clk_i);
          if (in_valid_i && in_stall_o) hold_seen = 1'b1;
        end
        out_stall_i <= 1'b0;
      end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(15, 1);
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : drive_side
    phase_t             ph;
    logic [3:0]         mode, run_mode;
    logic [7:0]         spd;
    logic signed [15:0] yaw, yaw_cur;
    int                 run_left, r, guard;
    in_valid_i      <= 1'b0;
    drive_mode_i    <= MODE_STOP;
    speed_request_i <= '0;
    yaw_now_i       <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_MIN_SPEED;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    cfg_min = MIN_SPEED_RST;
    cfg_max = MAX_SPEED_RST;
    cfg_gain = GAIN_RST;
    cfg_wup = WHEEL_UPPER_RST;
    cfg_wlo = WHEEL_LOWER_RST;
    mode_rec = MODE_STOP;
    latched_rec = REC_NONE;
    head_ref = '0;
    run_left = 0;
    run_mode = MODE_FWD;
    yaw_cur = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = phase_tab[p];
      if (!ph.keep_reset) begin
        if (ph.rnd_regs) begin
          ph.lo = 8'($urandom_range(255));
          ph.hi = 8'($urandom_range(255));
          ph.gain = 8'($urandom_range(255));
          ph.wup = 8'($urandom_range(255));
          ph.wlo = 8'($urandom_range(255));
        end
        write_reg(CFG_MIN_SPEED, ph.lo);
        write_reg(CFG_MAX_SPEED, ph.hi);
        write_reg(CFG_GAIN, ph.gain);
        write_reg(CFG_WHEEL_UPPER, ph.wup);
        write_reg(CFG_WHEEL_LOWER, ph.wlo);
        // unused index, must be ignored
        write_reg(CFG_IDX_W'(CFG_WHEEL_LOWER + CFG_IDX_W'($urandom_range(3, 1))),
                  8'($urandom));
        cfg_valid_i <= 1'b0;
      end
      src_idle_pct = ph.src_pct;
      sink_idle_pct = ph.sink_pct;
      if (ph.hold) hold_req = 1'b1;

      if (ph.keep_reset) begin
        foreach (directed_rows[i])
          send_cmd(directed_rows[i].mode, directed_rows[i].spd, directed_rows[i].yaw,
                   directed_rows[i].typed, directed_rows[i].res);
      end

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // mostly runs of straight moves with a drifting yaw so the heading hold
        // works on small errors; stops and bad codes inside a run keep the latch
        if (run_left == 0 && $urandom_range(99) < 60) begin
          run_mode = $urandom_range(1) ? MODE_FWD : MODE_BACK;
          run_left = $urandom_range(16, 3);
          yaw_cur = 16'($urandom);
        end
        if (run_left != 0) begin
          run_left--;
          r = $urandom_range(99);
          if (r < 8) mode = MODE_STOP;
          else if (r < 12) mode = 4'($urandom_range(MODE_BAD_HI, MODE_BAD_LO));
          else mode = run_mode;
          yaw_cur = yaw_cur + 16'($urandom_range(96)) - 16'sd48;
          yaw = yaw_cur;
        end else begin
          mode = 4'($urandom);
          yaw = 16'($urandom);
        end
        r = $urandom_range(99);
        if (r < 10) spd = 8'd0;
        else if (r < 20) spd = 8'd255;
        else spd = 8'($urandom_range(255));
        send_cmd(mode, spd, yaw, 1'b0, '0);
      end

      in_valid_i <= 1'b0;
      for (guard = 0; guard < 20000 && wheel_cmd_q.size() != 0; guard++)
        @(posedge clk_i);
      repeat (3) @(posedge clk_i);
    end

    if (wheel_cmd_q.size() != 0) begin
      $error("%0d wheel commands never arrived", wheel_cmd_q.size());
      mismatches += wheel_cmd_q.size();
    end
    $display("run: %0d drive commands, %0d wheel commands compared, %0d register settings",
             cmds_sent, cmds_checked, NUM_PHASES);
    $display("run: long result hold-off %s the command input",
             hold_seen ? "backed up" : "did not back up");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
